### src/pscd_pkg.sv
// Package with the shared types and constants of the per-source command deframer.
`timescale 1ns / 1ps

package pscd_pkg;

    localparam int SOURCES_DEF = 4;
    localparam int MSG_CAP_DEF = 256;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    localparam logic [1:0] CFG_OWN_NODE   = 2'd0;
    localparam logic [1:0] CFG_BROADCAST  = 2'd1;
    localparam logic [1:0] CFG_NUM_CMDS   = 2'd2;

    localparam logic [1:0] OWN_NODE_RST  = 2'd0;
    localparam logic [7:0] BROADCAST_RST = 8'd128;
    localparam logic [7:0] NUM_CMDS_RST  = 8'd64;

    typedef struct packed {
        logic [1:0] own_node;
        logic [7:0] broadcast_dest;
        logic [7:0] num_cmds;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] out_src;
        logic [1:0] kind;
        logic [6:0] cmd_num;
        logic [7:0] data;
        logic       truncated;
    } result_t;

endpackage

### src/pscd_frame_core.sv
// Framer state memory with read, modify and write back of one source record per word.
`timescale 1ns / 1ps

module pscd_frame_core
    import pscd_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEF,
    parameter int MSG_CAP = MSG_CAP_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       advance,
    input  logic [1:0] in_src,
    input  logic [7:0] in_byte,
    input  cfg_t       cfg,
    output result_t    result
);

    localparam int SRC_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int EXT_W = (SRC_W > 2) ? SRC_W : 2;
    localparam int LEN_W = $clog2(MSG_CAP);

    typedef struct packed {
        logic [7:0]       dest;
        logic [LEN_W-1:0] len;
        logic [7:0]       command;
        logic             overflowed;
    } rec_t;

    rec_t mem [SOURCES];

    logic [EXT_W-1:0] src_ext;
    logic [SRC_W-1:0] in_idx;
    logic             src_ok;
    logic             accept;

    logic             p1_valid_reg;
    logic [SRC_W-1:0] p1_idx_reg;
    logic [1:0]       p1_src_reg;
    logic [7:0]       p1_byte_reg;
    rec_t             rd_reg;

    logic             lw_valid_reg;
    logic [SRC_W-1:0] lw_idx_reg;
    rec_t             lw_rec_reg;

    logic [SOURCES-1:0] busy_reg;
    logic [SOURCES-1:0] busy_next;

    rec_t cur;
    rec_t wr_rec;
    logic cur_busy;
    logic deliv;
    logic cmd_ok;
    logic write_en;

    assign src_ext = EXT_W'(in_src);
    assign in_idx  = src_ext[SRC_W-1:0];
    assign src_ok  = (32'(in_src) < 32'(SOURCES));
    assign accept  = in_valid && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            busy_reg     <= '0;
        end else if (advance) begin
            p1_valid_reg <= accept && src_ok;
            busy_reg     <= busy_next;
            if (write_en) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg      <= mem[in_idx];
            p1_idx_reg  <= in_idx;
            p1_src_reg  <= in_src;
            p1_byte_reg <= in_byte;
        end
        if (advance && write_en) begin
            mem[p1_idx_reg] <= wr_rec;
            lw_idx_reg      <= p1_idx_reg;
            lw_rec_reg      <= wr_rec;
        end
    end

    always_comb begin
        cur = (lw_valid_reg && (lw_idx_reg == p1_idx_reg)) ? lw_rec_reg : rd_reg;
        cur_busy = busy_reg[p1_idx_reg];
        deliv = (cur.dest == {6'd0, cfg.own_node}) || (cur.dest == cfg.broadcast_dest);
        cmd_ok = !cur.command[7] && (cur.command != 8'd0) && (cur.command < cfg.num_cmds);
        write_en = p1_valid_reg;
        wr_rec = cur;
        busy_next = busy_reg;
        result = '0;
        result.out_src = p1_src_reg;
        result.cmd_num = cur.command[7] ? 7'd0 : cur.command[6:0];
        if (p1_valid_reg) begin
            if (p1_byte_reg != 8'd0) begin
                if (!cur_busy) begin
                    busy_next[p1_idx_reg] = 1'b1;
                    wr_rec.dest       = p1_byte_reg - 8'd1;
                    wr_rec.len        = '0;
                    wr_rec.command    = 8'd0;
                    wr_rec.overflowed = 1'b0;
                end else if (cur.len == '0) begin
                    wr_rec.command = p1_byte_reg;
                    wr_rec.len     = LEN_W'(1);
                end else if (cur.len >= LEN_W'(MSG_CAP - 1)) begin
                    wr_rec.overflowed = 1'b1;
                end else begin
                    wr_rec.len = cur.len + LEN_W'(1);
                    if (deliv && cmd_ok) begin
                        result.valid = 1'b1;
                        result.kind  = KIND_PAYLOAD;
                        result.data  = p1_byte_reg;
                    end
                end
            end else if (cur_busy) begin
                if (deliv) begin
                    result.valid     = 1'b1;
                    result.kind      = cmd_ok ? KIND_DONE : KIND_UNKNOWN;
                    result.truncated = cur.overflowed;
                end
                busy_next[p1_idx_reg] = 1'b0;
                wr_rec = '0;
            end
        end
    end

endmodule

### src/per_source_command_deframer_top.sv
// Top level of the per-source command deframer with configuration and output registers.
// The block takes one received byte per word on the s_ channel, tagged in s_tuser
// with the source that sent it, and keeps one framer record per source in a memory.
// Each result word on the m_ channel is a payload byte, a command completion record
// or an unknown-command record, tagged with its source.
// The user must see that configuration registers are written over the cfg_ channel
// while the block is idle; the block does not enforce this. The accepting edge reads
// the source's record from memory; when the output can advance, the record is updated
// and the result is loaded into the output register. Throughput is one byte per cycle
// unless the output stalls; a byte for the same source as the one before it is served
// by forwarding the last record written back. Reset clears the configuration to its
// defaults and marks every framer idle at once, so no clearing pass runs. When the
// receiver stalls with a result held, s_tready drops until it is taken.
`timescale 1ns / 1ps

module per_source_command_deframer_top
    import pscd_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEF,
    parameter int MSG_CAP = MSG_CAP_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic [1:0]  s_tuser,   // [1:0] src
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] cmd_num, [14:7] data, [15] truncated
    output logic [3:0]  m_tuser,   // [1:0] out_src, [3:2] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t    cfg_reg;
    result_t result;
    result_t out_reg;
    logic    advance;

    assign advance   = !(out_reg.valid && !m_tready);
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_node       <= OWN_NODE_RST;
            cfg_reg.broadcast_dest <= BROADCAST_RST;
            cfg_reg.num_cmds       <= NUM_CMDS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_OWN_NODE: begin
                    cfg_reg.own_node <= cfg_data[1:0];
                end
                CFG_BROADCAST: begin
                    cfg_reg.broadcast_dest <= cfg_data;
                end
                CFG_NUM_CMDS: begin
                    cfg_reg.num_cmds <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    pscd_frame_core #(
        .SOURCES(SOURCES),
        .MSG_CAP(MSG_CAP)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .advance (advance),
        .in_src  (s_tuser),
        .in_byte (s_tdata),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {out_reg.truncated, out_reg.data, out_reg.cmd_num};
    assign m_tuser  = {out_reg.kind, out_reg.out_src};

`ifndef NO_ASSERTIONS
    a_payload_not_truncated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[3:2] == KIND_PAYLOAD)) |-> !m_tdata[15])
        else $error("A payload word carries the truncated flag.");

    a_record_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[3:2] != KIND_PAYLOAD)) |-> (m_tdata[14:7] == 8'd0))
        else $error("A completion or unknown-command record carries nonzero data.");

    a_payload_has_command: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[3:2] == KIND_PAYLOAD)) |-> (m_tdata[6:0] != 7'd0))
        else $error("A payload word is streamed for a message without a valid command.");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the per-source command deframer top level.
`timescale 1ns / 1ps

module testbench;
    import pscd_pkg::*;

    localparam int SRC_N       = SOURCES_DEF;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic [1:0] src;
        logic [7:0] rx_byte;
        logic       typed;
        result_t    exp;
    } dir_row_t;

    localparam result_t NO_RESULT = '0;

    localparam dir_row_t DIRECTED [25] = '{
        '{2'd0, 8'h00, 1'b1, NO_RESULT},
        '{2'd0, 8'h01, 1'b0, NO_RESULT},
        '{2'd0, 8'h05, 1'b0, NO_RESULT},
        '{2'd0, 8'hFF, 1'b1, '{1'b1, 2'd0, KIND_PAYLOAD, 7'd5, 8'hFF, 1'b0}},
        '{2'd1, 8'h81, 1'b0, NO_RESULT},
        '{2'd0, 8'h01, 1'b1, '{1'b1, 2'd0, KIND_PAYLOAD, 7'd5, 8'h01, 1'b0}},
        '{2'd1, 8'h00, 1'b1, '{1'b1, 2'd1, KIND_UNKNOWN, 7'd0, 8'h00, 1'b0}},
        '{2'd0, 8'h00, 1'b1, '{1'b1, 2'd0, KIND_DONE, 7'd5, 8'h00, 1'b0}},
        '{2'd2, 8'h03, 1'b0, NO_RESULT},
        '{2'd2, 8'h07, 1'b0, NO_RESULT},
        '{2'd2, 8'h09, 1'b1, NO_RESULT},
        '{2'd2, 8'h00, 1'b1, NO_RESULT},
        '{2'd3, 8'h01, 1'b0, NO_RESULT},
        '{2'd3, 8'h80, 1'b0, NO_RESULT},
        '{2'd3, 8'h42, 1'b1, NO_RESULT},
        '{2'd3, 8'h00, 1'b1, '{1'b1, 2'd3, KIND_UNKNOWN, 7'd0, 8'h00, 1'b0}},
        '{2'd1, 8'h01, 1'b0, NO_RESULT},
        '{2'd1, 8'h3F, 1'b0, NO_RESULT},
        '{2'd1, 8'hAA, 1'b1, '{1'b1, 2'd1, KIND_PAYLOAD, 7'd63, 8'hAA, 1'b0}},
        '{2'd1, 8'h00, 1'b1, '{1'b1, 2'd1, KIND_DONE, 7'd63, 8'h00, 1'b0}},
        '{2'd0, 8'h01, 1'b0, NO_RESULT},
        '{2'd0, 8'h40, 1'b0, NO_RESULT},
        '{2'd0, 8'h00, 1'b1, '{1'b1, 2'd0, KIND_UNKNOWN, 7'd64, 8'h00, 1'b0}},
        '{2'd3, 8'hFF, 1'b0, NO_RESULT},
        '{2'd3, 8'h00, 1'b1, NO_RESULT}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic [1:0]  s_tuser   = 2'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data  = 8'd0;

    logic [1:0] own_r = OWN_NODE_RST;
    logic [7:0] bc_r  = BROADCAST_RST;
    logic [7:0] ncmds_r = NUM_CMDS_RST;

    logic       busy_r [SRC_N] = '{default: 1'b0};
    logic [7:0] dest_r [SRC_N] = '{default: 8'd0};
    int         len_r  [SRC_N] = '{default: 0};
    logic [7:0] cmd_r  [SRC_N] = '{default: 8'd0};
    logic       ovf_r  [SRC_N] = '{default: 1'b0};

    result_t    pending_results [$];
    logic [7:0] plan_q [SRC_N][$];

    int mismatches  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int hold_count  = 0;

    int rx_cycle  = 0;
    int rx_mode   = 0;
    int hold_left = 0;
    int hold_done = 0;

    per_source_command_deframer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic result_t frame_step(input logic [1:0] s, input logic [7:0] b);
        result_t    r;
        int         sc;
        logic       cmd_ok;
        logic       deliv;
        logic [6:0] clip;
        r      = NO_RESULT;
        sc     = $signed(cmd_r[s]);
        cmd_ok = (sc > 0) && (sc < int'(ncmds_r));
        clip   = (sc < 0) ? 7'd0 : 7'(sc);
        deliv  = (dest_r[s] == {6'd0, own_r}) || (dest_r[s] == bc_r);
        if (b != 8'd0) begin
            if (!busy_r[s]) begin
                busy_r[s] = 1'b1;
                dest_r[s] = b - 8'd1;
                len_r[s]  = 0;
                cmd_r[s]  = 8'd0;
                ovf_r[s]  = 1'b0;
            end else if (len_r[s] == 0) begin
                cmd_r[s] = b;
                len_r[s] = 1;
            end else if (len_r[s] >= MSG_CAP_DEF - 1) begin
                ovf_r[s] = 1'b1;
            end else begin
                len_r[s]++;
                if (deliv && cmd_ok) begin
                    r = '{1'b1, s, KIND_PAYLOAD, clip, b, 1'b0};
                end
            end
        end else if (busy_r[s]) begin
            if (deliv) begin
                r = '{1'b1, s, cmd_ok ? KIND_DONE : KIND_UNKNOWN, clip, 8'd0, ovf_r[s]};
            end
            busy_r[s] = 1'b0;
            dest_r[s] = 8'd0;
            len_r[s]  = 0;
            cmd_r[s]  = 8'd0;
            ovf_r[s]  = 1'b0;
        end
        return r;
    endfunction

    task automatic send_word(input logic [1:0] s, input logic [7:0] b, input logic typed,
                             input result_t exp);
        int      gap;
        result_t r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= s;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        r = frame_step(s, b);
        if (typed) begin
            r = exp;
        end
        if (r.valid) begin
            pending_results.push_back(r);
        end
    endtask

    task automatic apply_config(input logic [1:0] own, input logic [7:0] bc,
                                input logic [7:0] nc);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        idx = '{CFG_OWN_NODE, CFG_BROADCAST, CFG_NUM_CMDS};
        val = '{{6'd0, own}, bc, nc};
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx[i])
                CFG_OWN_NODE:  own_r   = val[i][1:0];
                CFG_BROADCAST: bc_r    = val[i];
                CFG_NUM_CMDS:  ncmds_r = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n);
        logic [1:0] s;
        logic [7:0] b;
        logic [7:0] cmd;
        int         top;
        int         len;
        for (int i = 0; i < n; i++) begin
            s = 2'($urandom_range(0, SRC_N - 1));
            if ($urandom_range(0, 7) == 0) begin
                b = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
            end else begin
                if (plan_q[s].size() == 0) begin
                    case ($urandom_range(0, 3))
                        0, 3: plan_q[s].push_back({6'd0, own_r} + 8'd1);
                        1:    plan_q[s].push_back(bc_r + 8'd1);
                        default: plan_q[s].push_back(8'($urandom_range(1, 255)));
                    endcase
                    top = (ncmds_r > 8'd128) ? 128 : int'(ncmds_r);
                    if (top > 1 && $urandom_range(0, 2) != 0) begin
                        cmd = 8'($urandom_range(1, top - 1));
                    end else begin
                        cmd = 8'($urandom_range(0, 255));
                    end
                    if (cmd != 8'd0) begin
                        plan_q[s].push_back(cmd);
                        len = $urandom_range(0, 6);
                        for (int k = 0; k < len; k++) begin
                            plan_q[s].push_back(8'($urandom_range(1, 255)));
                        end
                    end
                    plan_q[s].push_back(8'd0);
                    if ($urandom_range(0, 3) == 0) begin
                        plan_q[s].push_back(8'd0);
                    end
                end
                b = plan_q[s].pop_front();
            end
            send_word(s, b, 1'b0, NO_RESULT);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] e,
                                 input logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual tuser %0h tdata %0h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                compare_field("out_src", 32'(e.out_src), 32'(m_tuser[1:0]));
                compare_field("kind", 32'(e.kind), 32'(m_tuser[3:2]));
                compare_field("cmd_num", 32'(e.cmd_num), 32'(m_tdata[6:0]));
                compare_field("data", 32'(e.data), 32'(m_tdata[14:7]));
                compare_field("truncated", 32'(e.truncated), 32'(m_tdata[15]));
            end
        end
    end

    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 128 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_done != hold_count) begin
            hold_done = hold_count;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= (rx_cycle % 4 != 3);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            send_word(DIRECTED[i].src, DIRECTED[i].rx_byte, DIRECTED[i].typed,
                      DIRECTED[i].exp);
        end
        run_random(80);

        apply_config(2'd3, 8'd0, 8'd1);
        run_random(60);

        apply_config(2'd1, 8'd254, 8'd128);
        send_word(2'd2, 8'd0, 1'b0, NO_RESULT);
        send_word(2'd2, {6'd0, own_r} + 8'd1, 1'b0, NO_RESULT);
        send_word(2'd2, 8'h7F, 1'b0, NO_RESULT);
        for (int i = 0; i < 300; i++) begin
            send_word(2'd2, 8'($urandom_range(1, 255)), 1'b0, NO_RESULT);
        end
        send_word(2'd2, 8'd0, 1'b0, NO_RESULT);
        plan_q[2].delete();
        hold_count++;
        run_random(60);

        apply_config(2'd2, 8'($urandom_range(0, 254)), 8'd200);
        run_random(60);

        apply_config(2'd0, 8'd128, 8'd0);
        run_random(50);

        apply_config(2'($urandom_range(0, 3)), 8'($urandom_range(0, 254)),
                     8'($urandom_range(1, 128)));
        hold_count++;
        run_random(60);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
